// ----- rtl/core/cfsd_pkg.sv -----
package cfsd_pkg;

    localparam int MAX_LEN_DEFAULT = 256;

    localparam int TEXT_W  = 8;
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 8;
    localparam int MAG_W   = 31;

    // Field parse phase codes
    localparam logic [1:0] PH_SKIP   = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_TAIL   = 2'd2;

    localparam logic [TEXT_W-1:0] CH_NUL   = 8'h00;
    localparam logic [TEXT_W-1:0] CH_SPACE = 8'h20;
    localparam logic [TEXT_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [TEXT_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [TEXT_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [TEXT_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [TEXT_W-1:0] CH_NINE  = 8'h39;
    localparam logic [TEXT_W-1:0] CH_HIGH  = 8'h80;

    localparam logic [MAG_W-1:0]   MAG_MAX   = {MAG_W{1'b1}};
    localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};

    typedef struct packed {
        logic [TEXT_W-1:0] text_byte;
        logic              is_end;
    } text_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        field_index;
        logic                      overflow;
        logic                      last_field;
    } field_result_t;

endpackage

// ----- rtl/core/cfsd_input_stage.sv -----
module cfsd_input_stage
    import cfsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  text_item_t in_item,
    input  logic       advance,
    output logic       item_valid,
    output text_item_t item
);

    logic       valid_reg;
    logic       valid_next;
    text_item_t item_reg;
    logic       load;

    assign in_ready   = !valid_reg || advance;
    assign load       = in_valid && in_ready;
    assign valid_next = load || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- rtl/core/cfsd_field_engine.sv -----
module cfsd_field_engine
    import cfsd_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  text_item_t    item,
    output logic          emit,
    output field_result_t result
);

    localparam int POS_W = $clog2(MAX_LEN + 1);

    logic [1:0]         phase_reg, phase_next;
    logic               neg_reg, neg_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic               sat_reg, sat_next;
    logic [INDEX_W-1:0] count_reg, count_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               ended_reg, ended_next;

    logic [TEXT_W-1:0]  c;
    logic               is_digit;
    logic [MAG_W+3:0]   mag_x10;
    logic [MAG_W+3:0]   mag_sum;
    logic [VALUE_W-1:0] mag_ext;
    logic               last_flag;

    assign c        = item.text_byte;
    assign is_digit = c inside {[CH_ZERO:CH_NINE]};
    // times ten as two shifts and one add
    assign mag_x10  = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0};
    // low nibble of an ASCII digit is its value
    assign mag_sum  = mag_x10 + (MAG_W+4)'(c[3:0]);
    assign mag_ext  = {1'b0, mag_reg};

    assign result.value       = neg_reg ? (VALUE_W'(0) - mag_ext) : mag_ext;
    assign result.field_index = count_reg;
    assign result.overflow    = sat_reg;
    assign result.last_field  = last_flag;

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        sat_next   = sat_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        ended_next = ended_reg;
        emit       = 1'b0;
        last_flag  = 1'b0;

        if (step)
        begin
            if (item.is_end)
            begin
                emit       = !ended_reg;
                last_flag  = 1'b1;
                phase_next = PH_SKIP;
                neg_next   = 1'b0;
                mag_next   = '0;
                sat_next   = 1'b0;
                count_next = '0;
                pos_next   = '0;
                ended_next = 1'b0;
            end
            else if (!ended_reg && (pos_reg < POS_W'(MAX_LEN)))
            begin
                pos_next = pos_reg + POS_W'(1);
                if (c == CH_NUL)
                begin
                    emit       = 1'b1;
                    last_flag  = 1'b1;
                    phase_next = PH_SKIP;
                    neg_next   = 1'b0;
                    mag_next   = '0;
                    sat_next   = 1'b0;
                    count_next = '0;
                    pos_next   = '0;
                    ended_next = 1'b1;
                end
                else if (c == CH_COMMA)
                begin
                    emit       = 1'b1;
                    phase_next = PH_SKIP;
                    neg_next   = 1'b0;
                    mag_next   = '0;
                    sat_next   = 1'b0;
                    if (count_reg != INDEX_MAX)
                    begin
                        count_next = count_reg + INDEX_W'(1);
                    end
                end
                else
                begin
                    case (phase_reg)
                        PH_SKIP:
                        begin
                            if (c <= CH_SPACE || c >= CH_HIGH)
                            begin
                                phase_next = PH_SKIP;
                            end
                            else if (c == CH_MINUS)
                            begin
                                neg_next   = 1'b1;
                                phase_next = PH_DIGITS;
                            end
                            else if (c == CH_PLUS)
                            begin
                                phase_next = PH_DIGITS;
                            end
                            else if (is_digit)
                            begin
                                mag_next   = mag_sum[MAG_W-1:0];
                                phase_next = PH_DIGITS;
                            end
                            else
                            begin
                                phase_next = PH_TAIL;
                            end
                        end
                        PH_DIGITS:
                        begin
                            if (is_digit)
                            begin
                                if (!sat_reg)
                                begin
                                    if (mag_sum > {4'b0000, MAG_MAX})
                                    begin
                                        mag_next = MAG_MAX;
                                        sat_next = 1'b1;
                                    end
                                    else
                                    begin
                                        mag_next = mag_sum[MAG_W-1:0];
                                    end
                                end
                            end
                            else
                            begin
                                phase_next = PH_TAIL;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_TAIL;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            sat_reg   <= 1'b0;
            count_reg <= '0;
            pos_reg   <= '0;
            ended_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
            sat_reg   <= sat_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            ended_reg <= ended_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg |-> (mag_reg == MAG_MAX))
        else $error("saturated field without full-scale magnitude");

    assert property (@(posedge clk) disable iff (!rst_n)
        neg_reg |-> (phase_reg != PH_SKIP))
        else $error("sign taken while still skipping blanks");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.is_end) |=> (count_reg == '0 && pos_reg == '0 && !ended_reg))
        else $error("string end did not clear the string state");

    assert property (@(posedge clk) disable iff (!rst_n)
        ended_reg |-> (pos_reg == '0 && count_reg == '0))
        else $error("ended string kept position or field count");

endmodule

// ----- rtl/core/cfsd_output_stage.sv -----
module cfsd_output_stage
    import cfsd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  field_result_t result,
    output logic          free,
    output logic          out_valid,
    input  logic          out_ready,
    output field_result_t out_result
);

    logic          valid_reg;
    logic          valid_next;
    field_result_t result_reg;

    // slot is free this cycle if empty or being drained
    assign free       = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// ----- rtl/core/comma_field_signed_decimal_parser.sv -----
// Parses a text string, one byte per transaction, into one signed 32-bit integer per
// comma-separated field. Leading blanks (bytes 1..32 and 128..255) are skipped, one
// optional sign is taken, then decimal digits up to the first non-digit; a field with
// no digits gives 0 and a magnitude above 2^31-1 saturates with the overflow flag set.
// A comma closes a field, a zero byte or tlast closes the last field of the string;
// bytes past MAX_LEN are ignored until tlast. The block takes one byte every cycle while
// the output register can take a result; a byte passes the input register, then the field
// state update with its multiply-by-ten accumulate, which loads the output register with
// the result. A result held by the receiver stalls the input once both registers are full.
module comma_field_signed_decimal_parser
    import cfsd_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // is_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] value, [39:32] field_index
    output logic        m_axis_tuser,   // overflow
    output logic        m_axis_tlast    // last_field
);

    text_item_t    in_item;
    text_item_t    item;
    logic          item_valid;
    logic          advance;
    logic          step;
    logic          emit;
    logic          out_free;
    field_result_t result;
    field_result_t out_result;

    assign in_item.text_byte = s_axis_tdata;
    assign in_item.is_end    = s_axis_tlast;

    // move the held byte on whenever the output slot can take a result
    assign advance = out_free;
    assign step    = item_valid && advance;

    cfsd_input_stage u_input_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    cfsd_field_engine #(
        .MAX_LEN (MAX_LEN)
    ) u_field_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .emit   (emit),
        .result (result)
    );

    cfsd_output_stage u_output_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (emit),
        .result     (result),
        .free       (out_free),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (out_result)
    );

    assign m_axis_tdata = {out_result.field_index, out_result.value};
    assign m_axis_tuser = out_result.overflow;
    assign m_axis_tlast = out_result.last_field;

endmodule
